// ----- src/qmspi_pkg.sv -----
// Package for the four-channel PI speed controller: payload beat types,
// register map, reset values and fixed-point constants.
// No dependencies.
package qmspi_pkg;

    // Input actions
    typedef enum logic [1:0] {
        ACT_PULSE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_BYTE  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Input beat
    typedef struct packed {
        t_action    action;
        logic [1:0] channel;
        logic [7:0] command_byte;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [1:0]  motor;
        logic [15:0] duty;
        logic        forward;
        logic [7:0]  speed_code;
        logic        last;
    } t_out;

    // Register map, word index = paddr / 4
    localparam int CFG_ADDR_W = 5;
    typedef enum logic [2:0] {
        REG_SPEED_SCALE = 3'd0,
        REG_GAIN_NOW    = 3'd1,
        REG_GAIN_PREV   = 3'd2,
        REG_DUTY_MAX    = 3'd3,
        REG_FRAME_END   = 3'd4,
        REG_DIR_SPLIT   = 3'd5
    } t_reg;

    localparam logic [15:0] SPEED_SCALE_RST = 16'd1659;
    localparam logic [15:0] GAIN_NOW_RST    = 16'd100;
    localparam logic [15:0] GAIN_PREV_RST   = 16'hFFC4;   // -60
    localparam logic [15:0] DUTY_MAX_RST    = 16'd500;
    localparam logic [7:0]  FRAME_END_RST   = 8'd95;
    localparam logic [7:0]  DIR_SPLIT_RST   = 8'd50;

    // Datapath widths
    localparam int REF_W   = 19;   // largest reference is 255*0.02 rpm in Q16.16
    localparam int ERR_W   = 32;
    localparam int ACC_W   = 40;
    localparam int SPEED_W = 48;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 51;

    // Telemetry: floor(floor(speed*100 / 2^16) / 2)
    localparam logic [16:0] CODE_MUL    = 17'd100;
    localparam int          CODE_SHIFT  = 17;
    localparam logic [8:0]  CODE_FWD    = 9'd50;

    // Reference rounding: (v*2^17 + 50) / 100 via reciprocal, exact below 2^30
    localparam logic [24:0] REF_ROUND   = 25'd50;
    localparam logic [25:0] REF_RECIP   = 26'd42949673;
    localparam int          REF_R_SHIFT = 32;

    function automatic logic [REF_W-1:0] ref_from_byte(input logic [7:0] v);
        logic [24:0] x;
        logic [50:0] p;
        x = {v, 17'd0} + REF_ROUND;
        p = 51'(x) * 51'(REF_RECIP);
        return p[REF_R_SHIFT +: REF_W];
    endfunction

endpackage

// ----- src/quad_motor_speed_pi_controller.sv -----
// Four-channel incremental PI motor speed controller, top level.
// Depends on qmspi_pkg (beat types, register map, constants).
// Pulse, command-byte and idle beats are taken one per cycle while no tick is running.
// A tick runs each channel through one shared 33x17 multiplier, stepping through
// states SPEED, ERR, GAIN, SUM, ACC and DUTY and then holding its result beat in
// OUT until it is taken; the result beat is registered on leaving DUTY.
// Input is stalled from tick accept until the last result beat is taken.
// Synchronous reset clears counts, PI state, references and frame state and
// restores the register defaults.
module quad_motor_speed_pi_controller #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  qmspi_pkg::t_in                        i_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output qmspi_pkg::t_out                       o_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qmspi_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int                    CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0]       LAST_CH    = CH_W'(CHANNELS - 1);
    localparam logic [3:0]            FRAME_LEN  = 4'(CHANNELS + 1);
    localparam logic [3:0]            IDX_MAX    = 4'd15;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SPEED, ST_ERR, ST_GAIN, ST_SUM, ST_ACC, ST_DUTY, ST_OUT
    } t_state;

    // Configuration registers
    logic [15:0] r_speed_scale;
    logic [15:0] r_gain_now;
    logic [15:0] r_gain_prev;
    logic [15:0] r_duty_max;
    logic [7:0]  r_frame_end;
    logic [7:0]  r_dir_split;

    // Per-channel state
    logic [COUNT_BITS-1:0]           r_count    [CHANNELS];
    logic [qmspi_pkg::ACC_W-1:0]     r_acc      [CHANNELS];
    logic [qmspi_pkg::ERR_W-1:0]     r_prev     [CHANNELS];
    logic [qmspi_pkg::REF_W-1:0]     r_ref      [CHANNELS];
    logic                            r_rev      [CHANNELS];
    logic [qmspi_pkg::REF_W-1:0]     r_pend_ref [CHANNELS];
    logic                            r_pend_rev [CHANNELS];
    logic [3:0]                      r_byte_idx;

    // Sequencer and result register
    t_state                          r_state;
    logic [CH_W-1:0]                 r_ch;
    logic                            r_out_valid;
    qmspi_pkg::t_out                 r_out;

    // Datapath registers
    logic signed [qmspi_pkg::PROD_W-1:0]  r_prod;
    logic [qmspi_pkg::ERR_W-1:0]          r_err;
    logic                                 r_big;
    logic [7:0]                           r_code;
    logic [qmspi_pkg::SUM_W-1:0]          r_sum;

    logic                                 in_accept;
    logic                                 cfg_wr;
    logic signed [qmspi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [qmspi_pkg::MUL_B_W-1:0] mul_b;
    logic [qmspi_pkg::SPEED_W-1:0]        speed;
    logic [48:0]                          err_full;
    logic [qmspi_pkg::ERR_W-1:0]          err_sat;
    logic [21:0]                          code_base;
    logic [8:0]                           code_sum;
    logic [7:0]                           code_val;
    logic [qmspi_pkg::SUM_W:0]            acc_total;
    logic [qmspi_pkg::ACC_W-1:0]          acc_sat;
    logic [qmspi_pkg::ACC_W-1:0]          acc_cur;
    logic [22:0]                          duty_hi;
    logic [15:0]                          duty_val;
    logic                                 byte_rev;
    logic [7:0]                           byte_val;
    logic [3:0]                           idx_inc;

    assign in_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale <= qmspi_pkg::SPEED_SCALE_RST;
            r_gain_now    <= qmspi_pkg::GAIN_NOW_RST;
            r_gain_prev   <= qmspi_pkg::GAIN_PREV_RST;
            r_duty_max    <= qmspi_pkg::DUTY_MAX_RST;
            r_frame_end   <= qmspi_pkg::FRAME_END_RST;
            r_dir_split   <= qmspi_pkg::DIR_SPLIT_RST;
        end else if (cfg_wr) begin
            unique case (qmspi_pkg::t_reg'(paddr[4:2]))
                qmspi_pkg::REG_SPEED_SCALE: r_speed_scale <= pwdata[15:0];
                qmspi_pkg::REG_GAIN_NOW:    r_gain_now    <= pwdata[15:0];
                qmspi_pkg::REG_GAIN_PREV:   r_gain_prev   <= pwdata[15:0];
                qmspi_pkg::REG_DUTY_MAX:    r_duty_max    <= pwdata[15:0];
                qmspi_pkg::REG_FRAME_END:   r_frame_end   <= pwdata[7:0];
                qmspi_pkg::REG_DIR_SPLIT:   r_dir_split   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (qmspi_pkg::t_reg'(paddr[4:2]))
            qmspi_pkg::REG_SPEED_SCALE: prdata = {16'd0, r_speed_scale};
            qmspi_pkg::REG_GAIN_NOW:    prdata = {16'd0, r_gain_now};
            qmspi_pkg::REG_GAIN_PREV:   prdata = {16'd0, r_gain_prev};
            qmspi_pkg::REG_DUTY_MAX:    prdata = {16'd0, r_duty_max};
            qmspi_pkg::REG_FRAME_END:   prdata = {24'd0, r_frame_end};
            qmspi_pkg::REG_DIR_SPLIT:   prdata = {24'd0, r_dir_split};
            default:                    prdata = 32'd0;
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SPEED: begin
                mul_a = qmspi_pkg::MUL_A_W'(r_count[r_ch]);
                mul_b = {1'b0, r_speed_scale};
            end
            ST_ERR: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = qmspi_pkg::CODE_MUL;
            end
            ST_GAIN: begin
                mul_a = {r_err[31], r_err};
                mul_b = {r_gain_now[15], r_gain_now};
            end
            ST_SUM: begin
                mul_a = {r_prev[r_ch][31], r_prev[r_ch]};
                mul_b = {r_gain_prev[15], r_gain_prev};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Error: reference minus speed, clipped to 32-bit signed
    always_comb begin
        speed    = r_prod[qmspi_pkg::SPEED_W-1:0];
        err_full = {30'd0, r_ref[r_ch]} - {1'b0, speed};
        if (err_full[48:31] == '0 || err_full[48:31] == '1) begin
            err_sat = err_full[31:0];
        end else if (err_full[48]) begin
            err_sat = 32'h8000_0000;
        end else begin
            err_sat = 32'h7FFF_FFFF;
        end
    end

    // Telemetry byte from speed*100
    always_comb begin
        code_base = r_prod[qmspi_pkg::CODE_SHIFT +: 22];
        code_sum  = {1'b0, code_base[7:0]} + (r_rev[r_ch] ? 9'd0 : qmspi_pkg::CODE_FWD);
        if (r_big || (code_base[21:8] != '0) || code_sum[8]) begin
            code_val = 8'hFF;
        end else begin
            code_val = code_sum[7:0];
        end
    end

    // Second PI term added, then clipped to 40-bit signed
    always_comb begin
        acc_total = {r_sum[qmspi_pkg::SUM_W-1], r_sum}
                  + {{2{r_prod[qmspi_pkg::PROD_W-1]}}, r_prod};
        if (acc_total[51:39] == '0 || acc_total[51:39] == '1) begin
            acc_sat = acc_total[qmspi_pkg::ACC_W-1:0];
        end else if (acc_total[51]) begin
            acc_sat = {1'b1, 39'd0};
        end else begin
            acc_sat = {1'b0, {39{1'b1}}};
        end
    end

    // Duty: accumulator integer part, clamped, and zero when the reference is zero
    always_comb begin
        acc_cur = r_acc[r_ch];
        duty_hi = acc_cur[38:16];
        if (acc_cur[39] || (r_ref[r_ch] == '0)) begin
            duty_val = 16'd0;
        end else if (duty_hi > {7'd0, r_duty_max}) begin
            duty_val = r_duty_max;
        end else begin
            duty_val = duty_hi[15:0];
        end
    end

    // Command byte decode
    always_comb begin
        byte_rev = (i_in.command_byte < r_dir_split);
        byte_val = byte_rev ? i_in.command_byte : (i_in.command_byte - r_dir_split);
        idx_inc  = (r_byte_idx < IDX_MAX) ? (r_byte_idx + 4'd1) : r_byte_idx;
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == ST_ERR) begin
            r_err <= err_sat;
            r_big <= |speed[47:32];
        end
        if (r_state == ST_GAIN) begin
            r_code <= code_val;
        end
        if (r_state == ST_SUM) begin
            r_sum <= {{11{r_acc[r_ch][39]}}, r_acc[r_ch]}
                   + {r_prod[qmspi_pkg::PROD_W-1], r_prod};
        end
    end

    // Channel state: pulse counts, PI state, frame handling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_count[k]    <= '0;
                r_acc[k]      <= '0;
                r_prev[k]     <= '0;
                r_ref[k]      <= '0;
                r_rev[k]      <= 1'b0;
                r_pend_ref[k] <= '0;
                r_pend_rev[k] <= 1'b0;
            end
            r_byte_idx <= 4'd0;
        end else begin
            if (in_accept && i_in.action == qmspi_pkg::ACT_PULSE) begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (32'(i_in.channel) == k && r_count[k] != COUNT_MAX) begin
                        r_count[k] <= r_count[k] + 1'b1;
                    end
                end
            end
            if (in_accept && i_in.action == qmspi_pkg::ACT_BYTE) begin
                if (32'(r_byte_idx) < CHANNELS) begin
                    r_pend_ref[r_byte_idx[CH_W-1:0]] <= qmspi_pkg::ref_from_byte(byte_val);
                    r_pend_rev[r_byte_idx[CH_W-1:0]] <= byte_rev;
                end
                if (i_in.command_byte == r_frame_end) begin
                    // commit only a full frame; pending slot was not touched this beat
                    if (idx_inc == FRAME_LEN) begin
                        for (int k = 0; k < CHANNELS; k++) begin
                            r_ref[k] <= r_pend_ref[k];
                            r_rev[k] <= r_pend_rev[k];
                        end
                    end
                    r_byte_idx <= 4'd0;
                end else begin
                    r_byte_idx <= idx_inc;
                end
            end
            if (r_state == ST_SPEED) begin
                r_count[r_ch] <= '0;
            end
            if (r_state == ST_ACC) begin
                r_acc[r_ch]  <= acc_sat;
                r_prev[r_ch] <= r_err;
            end
        end
    end

    // Tick sequencer and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept && i_in.action == qmspi_pkg::ACT_TICK) begin
                        r_ch    <= '0;
                        r_state <= ST_SPEED;
                    end
                end
                ST_SPEED: r_state <= ST_ERR;
                ST_ERR:   r_state <= ST_GAIN;
                ST_GAIN:  r_state <= ST_SUM;
                ST_SUM:   r_state <= ST_ACC;
                ST_ACC:   r_state <= ST_DUTY;
                ST_DUTY: begin
                    r_out.motor      <= 2'(r_ch);
                    r_out.duty       <= duty_val;
                    r_out.forward    <= !r_rev[r_ch];
                    r_out.speed_code <= r_code;
                    r_out.last       <= (r_ch == LAST_CH);
                    r_out_valid      <= 1'b1;
                    r_state          <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_ch == LAST_CH) begin
                            r_ch    <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= ST_SPEED;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Checks
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_OUT))
        else $error("result valid outside output state");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && r_out.last) |=> (r_state == ST_IDLE))
        else $error("tick did not end after last beat");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPEED) |=> (r_count[r_ch] == '0))
        else $error("pulse count not cleared by tick");

    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.duty <= r_duty_max))
        else $error("duty above clamp");

endmodule
